// ===== src/feal_pkg.sv =====
package feal_pkg;

  typedef struct packed {
    logic        action;
    logic [31:0] word_first;
    logic [31:0] word_second;
  } in_word_t;

  typedef struct packed {
    logic [31:0] out_first;
    logic [31:0] out_second;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    REG_KEY0,
    REG_KEY1,
    REG_KEY2,
    REG_KEY3
  } reg_index_t;

  typedef enum logic [1:0] {
    QSEL_BOTH,
    QSEL_R1,
    QSEL_R2
  } qsel_t;

  localparam logic ACT_DECRYPT = 1'b1;

  function automatic logic [7:0] sbox_mix(input logic [7:0] x, input logic [7:0] y,
                                          input logic c);
    logic [7:0] t;
    t = x + y + {7'd0, c};
    return {t[5:0], t[7:6]};
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] x, input logic [15:0] k);
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] y0;
    logic [7:0] y3;
    m1 = x[23:16] ^ k[15:8] ^ x[31:24];
    m2 = x[15:8] ^ k[7:0] ^ x[7:0];
    m1 = sbox_mix(m1, m2, 1'b0);
    m2 = sbox_mix(m2, m1, 1'b1);
    y0 = sbox_mix(x[31:24], m1, 1'b1);
    y3 = sbox_mix(x[7:0], m2, 1'b0);
    return {y0, m1, m2, y3};
  endfunction

  function automatic logic [31:0] key_mix(input logic [31:0] a, input logic [31:0] b);
    logic [7:0] m1;
    logic [7:0] m2;
    logic [7:0] y0;
    logic [7:0] y3;
    m1 = a[23:16] ^ a[31:24];
    m2 = a[15:8] ^ a[7:0];
    m1 = sbox_mix(m1, m2 ^ b[31:24], 1'b1);
    m2 = sbox_mix(m2, m1 ^ b[23:16], 1'b0);
    y0 = sbox_mix(a[31:24], m1 ^ b[15:8], 1'b0);
    y3 = sbox_mix(a[7:0], m2 ^ b[7:0], 1'b1);
    return {y0, m1, m2, y3};
  endfunction

endpackage

// ===== src/feal_keysched.sv =====
module feal_keysched #(
  parameter int ROUNDS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           busy,
  input  logic [$clog2(ROUNDS)-2:0]      rd_row,
  output logic [31:0]                    rd_data,
  output logic [7:0][15:0]               wkey
);

  localparam int KS_STEPS = (ROUNDS + 1) / 2 + 4;
  localparam int RK_ROWS  = (ROUNDS + 1) / 2;
  localparam int ROW_W    = $clog2(ROUNDS) - 1;
  localparam int STEP_W   = $clog2(KS_STEPS);

  logic [3:0][31:0]  key;
  logic [STEP_W-1:0] step;
  feal_pkg::qsel_t   qsel;
  logic [31:0]       ka;
  logic [31:0]       kb;
  logic [31:0]       kd;
  logic [31:0]       a_cur;
  logic [31:0]       b_cur;
  logic [31:0]       d_cur;
  logic [31:0]       q;
  logic [31:0]       t;
  logic [31:0]       rk_mem [RK_ROWS];

  always_comb begin
    if (step == '0) begin
      a_cur = key[0];
      b_cur = key[1];
      d_cur = '0;
    end else begin
      a_cur = ka;
      b_cur = kb;
      d_cur = kd;
    end
    unique case (qsel)
      feal_pkg::QSEL_BOTH: q = key[2] ^ key[3];
      feal_pkg::QSEL_R1:   q = key[2];
      feal_pkg::QSEL_R2:   q = key[3];
      default:             q = key[2] ^ key[3];
    endcase
    t = feal_pkg::key_mix(a_cur, b_cur ^ d_cur ^ q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (feal_pkg::reg_index_t'(cfg_index))
        feal_pkg::REG_KEY0: key[0] <= cfg_data;
        feal_pkg::REG_KEY1: key[1] <= cfg_data;
        feal_pkg::REG_KEY2: key[2] <= cfg_data;
        feal_pkg::REG_KEY3: key[3] <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      busy <= 1'b1;
      step <= '0;
      qsel <= feal_pkg::QSEL_BOTH;
    end else if (busy) begin
      if (step == STEP_W'(KS_STEPS - 1)) begin
        busy <= 1'b0;
      end
      step <= step + 1'b1;
      unique case (qsel)
        feal_pkg::QSEL_BOTH: qsel <= feal_pkg::QSEL_R1;
        feal_pkg::QSEL_R1:   qsel <= feal_pkg::QSEL_R2;
        default:             qsel <= feal_pkg::QSEL_BOTH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      kd <= a_cur;
      ka <= b_cur;
      kb <= t;
      for (int j = 0; j < 8; j++) begin
        if (2 * int'(step) == ROUNDS + j) begin
          wkey[j] <= t[31:16];
        end
        if (2 * int'(step) + 1 == ROUNDS + j) begin
          wkey[j] <= t[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && int'(step) < RK_ROWS) begin
      rk_mem[step[ROW_W-1:0]] <= t;
    end
    rd_data <= rk_mem[rd_row];
  end

endmodule

// ===== src/feal_block_cipher_unit.sv =====
// A 64-bit Feistel block cipher with a 128-bit key held in four registers.
// The key is written through the configuration port; every write restarts
// the key schedule, which fills the subkey memory and the whitening keys.
// While the schedule runs, in_ready stays low.
// Reset clears the key to zero and runs the same schedule pass.
// An input word carries the action (encrypt or decrypt) and two 32-bit
// words. It is accepted when in_valid and in_ready are both high. One
// result word follows on out_valid/out_ready for every input word.
// An item is loaded and whitened when it is accepted, then runs one
// Feistel round per cycle, each using one read of the subkey memory,
// and is whitened and registered as the result. Words are
// processed one at a time. The result register lets the next word be
// accepted while a result waits; if the receiver stalls, a finished word
// holds in the core until the result register frees up.
module feal_block_cipher_unit #(
  parameter int ROUNDS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  feal_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output feal_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int IDX_W = $clog2(ROUNDS);

  feal_pkg::state_t  state;
  feal_pkg::state_t  state_next;
  logic              busy;
  logic [IDX_W-1:0]  key_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic              half_lo;
  logic              dec;
  logic [31:0]       a;
  logic [31:0]       b;
  logic [31:0]       rd_data;
  logic [7:0][15:0]  wkey;
  logic [15:0]       rk;
  logic              last;
  logic              accept;
  logic              load_out;
  logic [31:0]       wa;
  logic [31:0]       wb;
  logic [31:0]       a_init;

  feal_keysched #(
    .ROUNDS(ROUNDS)
  ) u_keysched (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .busy     (busy),
    .rd_row   (rd_idx[IDX_W-1:1]),
    .rd_data  (rd_data),
    .wkey     (wkey)
  );

  assign last = (dec == feal_pkg::ACT_DECRYPT) ? (key_idx == '0)
                                               : (key_idx == IDX_W'(ROUNDS - 1));
  assign rk   = half_lo ? rd_data[15:0] : rd_data[31:16];

  always_comb begin
    state_next = state;
    unique case (state)
      feal_pkg::ST_IDLE:  if (accept) state_next = feal_pkg::ST_ROUND;
      feal_pkg::ST_ROUND: if (last) state_next = feal_pkg::ST_DONE;
      feal_pkg::ST_DONE:  if (load_out) state_next = feal_pkg::ST_IDLE;
      default:            state_next = feal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == feal_pkg::ST_IDLE) && !busy;
    accept   = in_valid && in_ready;
    load_out = (state == feal_pkg::ST_DONE) && (!out_valid || out_ready);
    rd_idx   = key_idx;
    if (state == feal_pkg::ST_IDLE) begin
      rd_idx = (in_word.action == feal_pkg::ACT_DECRYPT) ? IDX_W'(ROUNDS - 1) : '0;
    end else if (state == feal_pkg::ST_ROUND && !last) begin
      rd_idx = (dec == feal_pkg::ACT_DECRYPT) ? key_idx - 1'b1 : key_idx + 1'b1;
    end
    if (in_word.action == feal_pkg::ACT_DECRYPT) begin
      wa = {wkey[4], wkey[5]};
      wb = {wkey[6], wkey[7]};
    end else begin
      wa = {wkey[0], wkey[1]};
      wb = {wkey[2], wkey[3]};
    end
    a_init = in_word.word_first ^ wa;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= feal_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    half_lo <= rd_idx[0];
    if (accept) begin
      dec     <= in_word.action;
      a       <= a_init;
      b       <= in_word.word_second ^ wb ^ a_init;
      key_idx <= rd_idx;
    end else if (state == feal_pkg::ST_ROUND) begin
      a       <= b;
      b       <= a ^ feal_pkg::round_fn(b, rk);
      key_idx <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (dec == feal_pkg::ACT_DECRYPT) begin
        out_word.out_first  <= b ^ {wkey[0], wkey[1]};
        out_word.out_second <= a ^ b ^ {wkey[2], wkey[3]};
      end else begin
        out_word.out_first  <= b ^ {wkey[4], wkey[5]};
        out_word.out_second <= a ^ b ^ {wkey[6], wkey[7]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/feal_checker.sv =====
module feal_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input feal_pkg::out_word_t out_word,
  input logic                cfg_we
);

  // The key schedule runs after reset, so no word can enter right away.
  assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // A key write restarts the schedule and blocks input.
  assert property (@(posedge clk) disable iff (rst) cfg_we |=> !in_ready)
    else $error("in_ready high right after a key write");

  // Words are processed one at a time.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in flight");

  // A result cannot appear the cycle after a word is accepted.
  assert property (@(posedge clk) disable iff (rst)
                   (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed or dropped");

endmodule

bind feal_block_cipher_unit feal_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word),
  .cfg_we   (cfg_we)
);

// ===== tb/tb_feal_block_cipher_unit.sv =====
`timescale 1ns / 1ps

module tb_feal_block_cipher_unit;

  localparam int ROUNDS = 32;
  localparam int KEY_STEPS = (ROUNDS + 1) / 2 + 4;
  localparam int SUBKEYS = KEY_STEPS * 2;
  localparam int IDLE_LIMIT = 2000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 85;
  localparam int DIRECTED_ROWS = 12;
  localparam logic ACT_ENCRYPT = ~feal_pkg::ACT_DECRYPT;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  feal_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  feal_pkg::out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] key_shadow [4];
  logic [15:0] subkeys [SUBKEYS];
  feal_pkg::out_word_t pending_blocks [$];

  int err_count = 0;
  int checked = 0;
  int sent_enc = 0;
  int sent_dec = 0;
  int key_loads = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_request = 1'b0;

  feal_pkg::in_word_t directed [DIRECTED_ROWS] = '{
    {ACT_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
    {feal_pkg::ACT_DECRYPT, 32'h0000_0000, 32'h0000_0000},
    {ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {feal_pkg::ACT_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    {ACT_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000},
    {feal_pkg::ACT_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF},
    {ACT_ENCRYPT, 32'h8000_0000, 32'h0000_0001},
    {feal_pkg::ACT_DECRYPT, 32'h0000_0001, 32'h8000_0000},
    {ACT_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555},
    {feal_pkg::ACT_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA},
    {ACT_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF},
    {feal_pkg::ACT_DECRYPT, 32'hFEDC_BA98, 32'h7654_3210}
  };

  always #6 clk = ~clk;

  feal_block_cipher_unit #(.ROUNDS(ROUNDS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic logic [7:0] rot_add(logic [7:0] x, logic [7:0] y, logic [7:0] c);
    logic [7:0] s;
    s = x + y + c;
    return (s << 2) | (s >> 6);
  endfunction

  function automatic logic [31:0] round_mix(logic [31:0] x, logic [15:0] k);
    logic [7:0] p;
    logic [7:0] q;
    p = x[23:16] ^ x[31:24] ^ k[15:8];
    q = x[15:8] ^ x[7:0] ^ k[7:0];
    p = rot_add(p, q, 8'd0);
    q = rot_add(q, p, 8'd1);
    return {rot_add(x[31:24], p, 8'd1), p, q, rot_add(x[7:0], q, 8'd0)};
  endfunction

  function automatic logic [31:0] key_fold(logic [31:0] a, logic [31:0] b);
    logic [7:0] p;
    logic [7:0] q;
    p = a[23:16] ^ a[31:24];
    q = a[15:8] ^ a[7:0];
    p = rot_add(p, q ^ b[31:24], 8'd1);
    q = rot_add(q, p ^ b[23:16], 8'd0);
    return {rot_add(a[31:24], p ^ b[15:8], 8'd0), p, q, rot_add(a[7:0], q ^ b[7:0], 8'd1)};
  endfunction

  function automatic void expand_key();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] d;
    logic [31:0] q;
    logic [31:0] t;
    a = key_shadow[0];
    b = key_shadow[1];
    d = '0;
    for (int s = 0; s < KEY_STEPS; s++) begin
      case (feal_pkg::qsel_t'(s % 3))
        feal_pkg::QSEL_BOTH: q = key_shadow[2] ^ key_shadow[3];
        feal_pkg::QSEL_R1: q = key_shadow[2];
        default: q = key_shadow[3];
      endcase
      t = key_fold(a, b ^ d ^ q);
      subkeys[2 * s] = t[31:16];
      subkeys[2 * s + 1] = t[15:0];
      d = a;
      a = b;
      b = t;
    end
  endfunction

  function automatic logic [31:0] whitening(int i);
    return {subkeys[ROUNDS + i], subkeys[ROUNDS + i + 1]};
  endfunction

  function automatic feal_pkg::out_word_t cipher_block(feal_pkg::in_word_t w);
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    feal_pkg::out_word_t o;
    if (w.action == feal_pkg::ACT_DECRYPT) begin
      r = w.word_first ^ whitening(4);
      l = (w.word_second ^ whitening(6)) ^ r;
      for (int i = ROUNDS - 1; i >= 0; i--) begin
        t = r ^ round_mix(l, subkeys[i]);
        r = l;
        l = t;
      end
      r ^= l;
      o.out_first = l ^ whitening(0);
      o.out_second = r ^ whitening(2);
    end else begin
      l = w.word_first ^ whitening(0);
      r = (w.word_second ^ whitening(2)) ^ l;
      for (int i = 0; i < ROUNDS; i++) begin
        t = l ^ round_mix(r, subkeys[i]);
        l = r;
        r = t;
      end
      l ^= r;
      o.out_first = r ^ whitening(4);
      o.out_second = l ^ whitening(6);
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 70);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic load_keys(input logic [3:0] mask, input logic [3:0][31:0] vals);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we <= 1'b1;
        cfg_index <= feal_pkg::reg_index_t'(i);
        cfg_data <= vals[i];
        key_shadow[i] = vals[i];
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    expand_key();
    key_loads++;
  endtask

  task automatic send_block(input feal_pkg::in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_blocks.push_back(cipher_block(w));
    if (w.action == feal_pkg::ACT_DECRYPT) begin
      sent_dec++;
    end else begin
      sent_enc++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall_left;
    feal_pkg::out_word_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_blocks.size() == 0) begin
          $error("Result word with no block pending: %h", out_word);
          err_count++;
        end else begin
          want = pending_blocks.pop_front();
          checked++;
          if (out_word.out_first !== want.out_first) begin
            $error("out_first: expected %h, got %h", want.out_first, out_word.out_first);
            err_count++;
          end
          if (out_word.out_second !== want.out_second) begin
            $error("out_second: expected %h, got %h", want.out_second, out_word.out_second);
            err_count++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (no_gaps || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("No word moved for %0d cycles.", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    feal_pkg::in_word_t blk;
    feal_pkg::out_word_t last_cipher;
    bit have_cipher;
    have_cipher = 1'b0;
    for (int i = 0; i < 4; i++) begin
      key_shadow[i] = '0;
    end
    expand_key();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The reset key is all zeros; the second pass uses the all-ones key.
    foreach (directed[i]) begin
      send_block(directed[i]);
    end
    drain_results();
    load_keys(4'hF, {4{32'hFFFF_FFFF}});
    foreach (directed[i]) begin
      send_block(directed[i]);
    end
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: load_keys(4'b0100, {4{rand_word()}});
        2: load_keys(4'hF, {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
        4: load_keys(4'b0001, {4{rand_word()}});
        5: load_keys(4'b1000, {4{rand_word()}});
        6: load_keys(4'hF, '0);
        default: load_keys(4'hF, {$urandom(), $urandom(), $urandom(), $urandom()});
      endcase
      no_gaps = (ph == 2);
      if (ph == 3) begin
        hold_request = 1'b1;
      end
      have_cipher = 1'b0;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Some decrypt words take back a recent ciphertext of the same key.
        if (have_cipher && $urandom_range(0, 3) == 0) begin
          blk.action = feal_pkg::ACT_DECRYPT;
          blk.word_first = last_cipher.out_first;
          blk.word_second = last_cipher.out_second;
        end else begin
          blk.action = $urandom_range(0, 1) ? feal_pkg::ACT_DECRYPT : ACT_ENCRYPT;
          blk.word_first = rand_word();
          blk.word_second = rand_word();
        end
        if (blk.action == ACT_ENCRYPT) begin
          last_cipher = cipher_block(blk);
          have_cipher = 1'b1;
        end
        send_block(blk);
      end
      drain_results();
    end
    no_gaps = 1'b0;

    repeat (ROUNDS + 10) @(posedge clk);
    $display("Checked %0d result words: %0d encrypt and %0d decrypt blocks.",
             checked, sent_enc, sent_dec);
    $display("Covered %0d key loads, a gap-free burst and a long output stall.", key_loads);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
